// ===== sv/irb_pkg.sv =====
// Package for the bilinear image rotator: sizes, register indexes, fixed-point constants.
// No dependencies.
package irb_pkg;
  localparam int MAX_COLS = 512;
  localparam int MAX_ROWS = 512;
  localparam int FRAC_BITS = 8;
  localparam int QBITS = 14;
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int BCW = CW - 1;
  localparam int BRW = RW - 1;
  localparam int BAW = BCW + BRW;
  localparam int BDEPTH = (MAX_COLS / 2) * (MAX_ROWS / 2);
  localparam int PW = 40;
  localparam int WB = FRAC_BITS + 1;

  typedef enum logic [2:0] {
    REG_SRC_COLS = 3'd0,
    REG_SRC_ROWS = 3'd1,
    REG_DST_COLS = 3'd2,
    REG_DST_ROWS = 3'd3,
    REG_COS_Q    = 3'd4,
    REG_SIN_Q    = 3'd5,
    REG_GRAY     = 3'd6
  } reg_idx_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
endpackage

// ===== sv/image_rotate_bilinear.sv =====
// Top level of the bilinear image rotator: config registers, banked frame store, pipeline.
// Depends on irb_pkg.
//
// Usage:
//   start/busy command channel. busy is always low: one transaction per clock.
//   func=0 loads one pixel at (row,col); func=1 queries a destination pixel.
//   Each query gives one result on out_ch*/inside_res with done high for one cycle,
//   after pipeline stages 1 to 5. Loads give no result.
//   Throughput: one item per cycle. The frame store is split into four banks by
//   row and column parity, so the four neighbours are read in the same cycle.
//   A load and a later query of the same pixel cannot collide: a load writes and
//   a query reads the banks at the edge after acceptance, in order.
//   Configuration: cfg_we/cfg_idx/cfg_data, written while idle.
//   Reset: rst (synchronous) restores register defaults and clears the pipeline.
//   The frame store is not cleared. The receiver cannot stall.
module image_rotate_bilinear (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [9:0]  row,
  input  logic [9:0]  col,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic        inside_res
);
  import irb_pkg::*;

  logic [9:0] src_cols, src_rows, dst_cols, dst_rows;
  logic signed [15:0] cos_q, sin_q;
  logic gray_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols <= 10'd512; src_rows <= 10'd512;
      dst_cols <= 10'd512; dst_rows <= 10'd512;
      cos_q <= 16'sd16384; sin_q <= 16'sd0; gray_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SRC_COLS: src_cols <= cfg_data[9:0];
        REG_SRC_ROWS: src_rows <= cfg_data[9:0];
        REG_DST_COLS: dst_cols <= cfg_data[9:0];
        REG_DST_ROWS: dst_rows <= cfg_data[9:0];
        REG_COS_Q:    cos_q <= cfg_data;
        REG_SIN_Q:    sin_q <= cfg_data;
        REG_GRAY:     gray_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // effective source size
  logic [12:0] cols, rows;
  always_comb begin
    cols = (src_cols == 10'd0) ? 13'd1 : 13'(src_cols);
    if (cols > 13'(MAX_COLS)) cols = 13'(MAX_COLS);
    rows = (src_rows == 10'd0) ? 13'd1 : 13'(src_rows);
    if (rows > 13'(MAX_ROWS)) rows = 13'(MAX_ROWS);
  end

  // stage 1: products
  logic v1, q1;
  logic [9:0] lrow, lcol;
  logic [23:0] ldata;
  logic signed [31:0] pxc, pys, pxs, pyc;
  logic signed [10:0] dx, dy;
  assign dx = $signed({1'b0, col}) - $signed({2'b0, dst_cols[9:1]});
  assign dy = $signed({1'b0, row}) - $signed({2'b0, dst_rows[9:1]});

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    q1 <= func;
    lrow <= row; lcol <= col;
    ldata <= {in_ch2, in_ch1, in_ch0};
    pxc <= 32'(dx * cos_q);
    pys <= 32'(dy * sin_q);
    pxs <= 32'(dx * sin_q);
    pyc <= 32'(dy * cos_q);
  end

  // stage 2: positions, bounds, neighbour addresses, bank reads
  logic signed [PW-1:0] xq, yq;
  logic ins;
  logic [PW-1:0] xf, yf;
  logic [12:0] x1, y1, x2, y2;
  assign xq = PW'($signed({1'b0, cols[12:1]}) <<< QBITS) + PW'(pxc) - PW'(pys);
  assign yq = PW'($signed({1'b0, rows[12:1]}) <<< QBITS) + PW'(pxs) + PW'(pyc);
  assign ins = !xq[PW-1] && !yq[PW-1] &&
               (xq < ($signed({1'b0, PW'(cols)}) <<< QBITS)) &&
               (yq < ($signed({1'b0, PW'(rows)}) <<< QBITS));
  assign xf = xq >> (QBITS - FRAC_BITS);
  assign yf = yq >> (QBITS - FRAC_BITS);
  assign x1 = 13'(xf >> FRAC_BITS);
  assign y1 = 13'(yf >> FRAC_BITS);
  assign x2 = (x1 + 13'd1 < cols) ? x1 + 13'd1 : cols - 13'd1;
  assign y2 = (y1 + 13'd1 < rows) ? y1 + 13'd1 : rows - 13'd1;

  // a pixel at (y,x) sits in bank {y[0],x[0]} at {y>>1,x>>1}
  logic [CW-1:0] xe, xo;
  logic [RW-1:0] ye, yo;
  always_comb begin
    xe = x1[0] ? CW'(x2) : CW'(x1);
    xo = x1[0] ? CW'(x1) : CW'(x2);
    ye = y1[0] ? RW'(y2) : RW'(y1);
    yo = y1[0] ? RW'(y1) : RW'(y2);
  end

  logic [23:0] bank0 [BDEPTH], bank1 [BDEPTH], bank2 [BDEPTH], bank3 [BDEPTH];
  logic [23:0] r0, r1, r2, r3;
  logic lwe;
  logic [1:0] lb;
  logic [BAW-1:0] la;
  assign lwe = v1 && (q1 == FUNC_LOAD) && (lrow < 10'(MAX_ROWS)) && (lcol < 10'(MAX_COLS));
  assign lb = {lrow[0], lcol[0]};
  assign la = {BRW'(lrow >> 1), BCW'(lcol >> 1)};

  always_ff @(posedge clk) begin
    if (lwe && lb == 2'd0) bank0[la] <= ldata;
    if (lwe && lb == 2'd1) bank1[la] <= ldata;
    if (lwe && lb == 2'd2) bank2[la] <= ldata;
    if (lwe && lb == 2'd3) bank3[la] <= ldata;
    r0 <= bank0[{ye[RW-1:1], xe[CW-1:1]}];
    r1 <= bank1[{ye[RW-1:1], xo[CW-1:1]}];
    r2 <= bank2[{yo[RW-1:1], xe[CW-1:1]}];
    r3 <= bank3[{yo[RW-1:1], xo[CW-1:1]}];
  end

  logic v2, ins2, gray2, xc2, yc2;
  logic [1:0] par2;
  logic [FRAC_BITS-1:0] u2, vv2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1 && (q1 == FUNC_QUERY);
    ins2 <= ins;
    gray2 <= gray_mode;
    par2 <= {y1[0], x1[0]};
    xc2 <= (x2 == x1);
    yc2 <= (y2 == y1);
    u2 <= yf[FRAC_BITS-1:0];
    vv2 <= xf[FRAC_BITS-1:0];
  end

  // stage 3: weights and neighbour unscramble
  logic [23:0] b11, b12, b21, b22;
  logic [23:0] p11, p12, p21, p22;
  always_comb begin
    case (par2)
      2'd0: begin b11 = r0; b12 = r1; b21 = r2; b22 = r3; end
      2'd1: begin b11 = r1; b12 = r0; b21 = r3; b22 = r2; end
      2'd2: begin b11 = r2; b12 = r3; b21 = r0; b22 = r1; end
      default: begin b11 = r3; b12 = r2; b21 = r1; b22 = r0; end
    endcase
    // a far neighbour clamped at the edge is the near pixel of the same bank
    p11 = b11;
    p12 = xc2 ? b11 : b12;
    p21 = yc2 ? b11 : b21;
    p22 = xc2 ? p21 : (yc2 ? p12 : b22);
  end

  logic [WB-1:0] wu, wv, uu, vv;
  assign uu = WB'(u2);
  assign vv = WB'(vv2);
  assign wu = WB'(1 << FRAC_BITS) - uu;
  assign wv = WB'(1 << FRAC_BITS) - vv;

  logic v3, ins3, gray3;
  logic [23:0] q11, q12, q21, q22;
  logic [2*WB-1:0] w11, w12, w21, w22;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    ins3 <= ins2; gray3 <= gray2;
    q11 <= p11; q12 <= p12; q21 <= p21; q22 <= p22;
    w11 <= wu * wv; w12 <= wu * vv; w21 <= uu * wv; w22 <= uu * vv;
  end

  // stage 4: per-channel products; stage 5: sum
  logic [2*WB+7:0] m [3][4];
  logic v4, ins4, gray4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    ins4 <= ins3; gray4 <= gray3;
    for (int c = 0; c < 3; c++) begin
      m[c][0] <= w11 * q11[8*c +: 8];
      m[c][1] <= w12 * q12[8*c +: 8];
      m[c][2] <= w21 * q21[8*c +: 8];
      m[c][3] <= w22 * q22[8*c +: 8];
    end
  end

  logic [2*WB+9:0] s [3];
  always_comb begin
    for (int c = 0; c < 3; c++)
      s[c] = (2*WB+10)'(m[c][0]) + (2*WB+10)'(m[c][1]) +
             (2*WB+10)'(m[c][2]) + (2*WB+10)'(m[c][3]);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v4;
    inside_res <= ins4;
    out_ch0 <= ins4 ? 8'(s[0] >> (2*FRAC_BITS)) : 8'd0;
    out_ch1 <= (ins4 && !gray4) ? 8'(s[1] >> (2*FRAC_BITS)) : 8'd0;
    out_ch2 <= (ins4 && !gray4) ? 8'(s[2] >> (2*FRAC_BITS)) : 8'd0;
  end
endmodule

// ===== sv/irb_checker.sv =====
// Port-level checks for image_rotate_bilinear, bound to the top level.
// Depends on irb_pkg.
module irb_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       func,
  input logic       done,
  input logic [7:0] out_ch0,
  input logic [7:0] out_ch1,
  input logic [7:0] out_ch2,
  input logic       inside_res
);
  import irb_pkg::*;

  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_QUERY) |-> ##5 done) else $error("missing result");
  a_noload: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_LOAD) |-> ##5 !done) else $error("load gave result");
  a_out0: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_res) |-> (out_ch0 == 8'd0 && out_ch1 == 8'd0 && out_ch2 == 8'd0))
    else $error("outside point not zero");
  a_rst: assert property (@(posedge clk) rst |=> !done) else $error("done after reset");
endmodule

bind image_rotate_bilinear irb_checker u_irb_checker (.*);

// ===== tb/image_rotate_bilinear_test.sv =====
// Self-checking testbench for image_rotate_bilinear: loads the frame store, then sends
// directed and random load and query transactions over several rotation settings.
// Depends on irb_pkg and the image_rotate_bilinear RTL.
module image_rotate_bilinear_test;
  timeunit 1ns;
  timeprecision 1ps;
  import irb_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       ins;
  } pix_t;

  typedef struct {
    logic       f;
    logic [9:0] r;
    logic [9:0] c;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    bit         typed;
    pix_t       e;
  } stim_t;

  typedef struct {
    logic [9:0]        sc;
    logic [9:0]        sr;
    logic [9:0]        dc;
    logic [9:0]        dr;
    logic signed [15:0] cq;
    logic signed [15:0] sq;
    logic              g;
    bit                calm;
    bit                fenced;
  } setting_t;

  logic clk, rst, start, busy, func, cfg_we, done, inside_res;
  logic [9:0] row, col;
  logic [7:0] in_ch0, in_ch1, in_ch2, out_ch0, out_ch1, out_ch2;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_data;

  logic [23:0] frame_mirror [MAX_ROWS*MAX_COLS];
  logic [9:0] m_scols, m_srows, m_dcols, m_drows;
  logic signed [15:0] m_cos, m_sin;
  logic m_gray;
  bit calm;
  bit fenced;
  pix_t pending_pixels[$];
  int errors;

  image_rotate_bilinear u_top (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic pix_t rotate_sample(logic [9:0] r, logic [9:0] c);
    longint cols, rows, dx, dy, xq, yq, xf, yf, u, v, x1, y1, x2, y2, s;
    logic [23:0] p11, p12, p21, p22;
    pix_t res;
    cols = (m_scols == 0) ? 1 : ((m_scols > MAX_COLS) ? MAX_COLS : m_scols);
    rows = (m_srows == 0) ? 1 : ((m_srows > MAX_ROWS) ? MAX_ROWS : m_srows);
    dx = longint'(c) - longint'(m_dcols / 2);
    dy = longint'(r) - longint'(m_drows / 2);
    xq = (cols / 2) * 16384 + dx * longint'(m_cos) - dy * longint'(m_sin);
    yq = (rows / 2) * 16384 + dx * longint'(m_sin) + dy * longint'(m_cos);
    res = '0;
    if (xq < 0 || yq < 0 || xq >= cols * 16384 || yq >= rows * 16384) return res;
    xf = xq >> (QBITS - FRAC_BITS);
    yf = yq >> (QBITS - FRAC_BITS);
    v = xf & 255;
    u = yf & 255;
    x1 = xf >> FRAC_BITS;
    y1 = yf >> FRAC_BITS;
    x2 = (x1 + 1 < cols) ? x1 + 1 : cols - 1;
    y2 = (y1 + 1 < rows) ? y1 + 1 : rows - 1;
    p11 = frame_mirror[y1 * MAX_COLS + x1];
    p12 = frame_mirror[y1 * MAX_COLS + x2];
    p21 = frame_mirror[y2 * MAX_COLS + x1];
    p22 = frame_mirror[y2 * MAX_COLS + x2];
    for (int ch = 0; ch < (m_gray ? 1 : 3); ch++) begin
      s = (256 - u) * (256 - v) * p11[8*ch +: 8] + (256 - u) * v * p12[8*ch +: 8]
        + u * (256 - v) * p21[8*ch +: 8] + u * v * p22[8*ch +: 8];
      if (ch == 0) res.c0 = 8'(s >> 16);
      else if (ch == 1) res.c1 = 8'(s >> 16);
      else res.c2 = 8'(s >> 16);
    end
    res.ins = 1'b1;
    return res;
  endfunction

  // one transaction; prediction happens on acceptance
  task automatic send(stim_t s);
    if (!calm && $urandom_range(99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= s.f;
    row <= s.r;
    col <= s.c;
    in_ch0 <= s.a;
    in_ch1 <= s.b;
    in_ch2 <= s.d;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (s.f == FUNC_LOAD) begin
      if (s.r < MAX_ROWS && s.c < MAX_COLS) frame_mirror[s.r * MAX_COLS + s.c] = {s.d, s.b, s.a};
    end else begin
      pending_pixels.push_back(s.typed ? s.e : rotate_sample(s.r, s.c));
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_COLS: m_scols = data[9:0];
      REG_SRC_ROWS: m_srows = data[9:0];
      REG_DST_COLS: m_dcols = data[9:0];
      REG_DST_ROWS: m_drows = data[9:0];
      REG_COS_Q:    m_cos = data;
      REG_SIN_Q:    m_sin = data;
      REG_GRAY:     m_gray = data[0];
      default: ;
    endcase
  endtask

  function automatic stim_t random_item();
    stim_t s;
    s.typed = 1'b0;
    s.e = '0;
    s.a = 8'($urandom);
    s.b = 8'($urandom);
    s.d = 8'($urandom);
    s.f = ($urandom_range(99) < 70) ? FUNC_QUERY : FUNC_LOAD;
    if (!fenced && $urandom_range(9) == 0) begin
      s.r = 10'($urandom);
      s.c = 10'($urandom);
    end else if (s.f == FUNC_QUERY) begin
      s.r = 10'($urandom_range(int'(m_drows) + 3));
      s.c = 10'($urandom_range(int'(m_dcols) + 3));
    end else begin
      s.r = 10'($urandom_range((m_srows > MAX_ROWS || m_srows == 0) ?
                               MAX_ROWS - 1 : m_srows - 1));
      s.c = 10'($urandom_range((m_scols > MAX_COLS || m_scols == 0) ?
                               MAX_COLS - 1 : m_scols - 1));
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report("result with no query waiting");
      end else begin
        pix_t e;
        e = pending_pixels.pop_front();
        if (out_ch0 !== e.c0) report($sformatf("out_ch0 %0d exp %0d", out_ch0, e.c0));
        if (out_ch1 !== e.c1) report($sformatf("out_ch1 %0d exp %0d", out_ch1, e.c1));
        if (out_ch2 !== e.c2) report($sformatf("out_ch2 %0d exp %0d", out_ch2, e.c2));
        if (inside_res !== e.ins) report($sformatf("inside_res %0b exp %0b", inside_res, e.ins));
      end
    end
  end

  initial begin
    stim_t directed [$];
    setting_t phases [$];
    stim_t s;
    errors = 0;
    calm = 1'b0;
    fenced = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_LOAD;
    row = '0;
    col = '0;
    in_ch0 = '0;
    in_ch1 = '0;
    in_ch2 = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_SRC_COLS;
    cfg_data = '0;
    m_scols = 10'd512;
    m_srows = 10'd512;
    m_dcols = 10'd512;
    m_drows = 10'd512;
    m_cos = 16'sd16384;
    m_sin = 16'sd0;
    m_gray = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every pixel that a query below can read: the top-left 16x16 corner
    // and a strip of row 0 around column 256
    calm = 1'b1;
    s.f = FUNC_LOAD;
    s.typed = 1'b0;
    s.e = '0;
    for (int r = 0; r < 16; r++) begin
      for (int c = 0; c < 16; c++) begin
        s.r = 10'(r);
        s.c = 10'(c);
        s.a = 8'($urandom);
        s.b = 8'($urandom);
        s.d = 8'($urandom);
        send(s);
      end
    end
    for (int c = 248; c < 272; c++) begin
      s.r = 10'd0;
      s.c = 10'(c);
      s.a = 8'($urandom);
      s.b = 8'($urandom);
      s.d = 8'($urandom);
      send(s);
    end
    calm = 1'b0;

    // reset settings: identity mapping, centers at 256
    directed = '{
      '{FUNC_LOAD,  10'd5,    10'd7,    8'h11, 8'h22, 8'h33, 1'b0, '0},
      '{FUNC_QUERY, 10'd5,    10'd7,    8'h00, 8'h00, 8'h00, 1'b1, {8'h11, 8'h22, 8'h33, 1'b1}},
      '{FUNC_LOAD,  10'd0,    10'd0,    8'hff, 8'hff, 8'hff, 1'b0, '0},
      '{FUNC_QUERY, 10'd0,    10'd0,    8'hff, 8'hff, 8'hff, 1'b1, {8'hff, 8'hff, 8'hff, 1'b1}},
      '{FUNC_LOAD,  10'd511,  10'd511,  8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{FUNC_QUERY, 10'd511,  10'd511,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 8'h00, 8'h00, 1'b1}},
      '{FUNC_LOAD,  10'd1023, 10'd3,    8'haa, 8'h55, 8'hf0, 1'b0, '0},
      '{FUNC_LOAD,  10'd3,    10'd600,  8'h55, 8'haa, 8'h0f, 1'b0, '0},
      '{FUNC_LOAD,  10'd1023, 10'd1023, 8'hff, 8'h00, 8'hff, 1'b0, '0},
      '{FUNC_QUERY, 10'd0,    10'd1023, 8'h00, 8'h00, 8'h00, 1'b1, '0},
      '{FUNC_QUERY, 10'd1023, 10'd0,    8'h00, 8'h00, 8'h00, 1'b1, '0},
      '{FUNC_QUERY, 10'd512,  10'd0,    8'h00, 8'h00, 8'h00, 1'b1, '0},
      '{FUNC_QUERY, 10'd1023, 10'd1023, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{FUNC_QUERY, 10'd3,    10'd3,    8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{FUNC_QUERY, 10'd9,    10'd10,   8'h00, 8'h00, 8'h00, 1'b0, '0}
    };
    foreach (directed[i]) send(directed[i]);
    settle();

    // source sizes stay inside the filled corner; the oversized source maps onto
    // the row 0 strip only, so its queries stay near the destination
    phases = '{
      '{10'd16,   10'd16,   10'd16,   10'd16,   16'sd16384,  16'sd0,      1'b0, 1'b0, 1'b0},
      '{10'd16,   10'd16,   10'd20,   10'd20,   16'sd11585,  16'sd11585,  1'b0, 1'b1, 1'b0},
      '{10'd16,   10'd12,   10'd24,   10'd20,   16'sd0,      16'sd16384,  1'b0, 1'b0, 1'b0},
      '{10'd1,    10'd1,    10'd1,    10'd1,    -16'sd16384, 16'sd0,      1'b1, 1'b0, 1'b0},
      '{10'd0,    10'd15,   10'd1023, 10'd1023, -16'sd16384, -16'sd16384, 1'b0, 1'b0, 1'b0},
      '{10'd15,   10'd13,   10'd1023, 10'd1023, 16'sd32767,  -16'sd32768, 1'b1, 1'b0, 1'b0},
      '{10'd1023, 10'd0,    10'd16,   10'd1,    16'sd16384,  16'sd0,      1'b0, 1'b0, 1'b1},
      '{10'd16,   10'd14,   10'd24,   10'd24,   16'sd9000,   -16'sd13000, 1'b0, 1'b0, 1'b0},
      '{10'd7,    10'd5,    10'd9,    10'd9,    -16'sd5000,  16'sd15000,  1'b1, 1'b0, 1'b0}
    };
    foreach (phases[p]) begin
      if (p >= 7) begin
        phases[p].cq = 16'($urandom_range(32768) - 16384);
        phases[p].sq = 16'($urandom_range(32768) - 16384);
      end
      write_reg(REG_SRC_COLS, 16'(phases[p].sc));
      write_reg(REG_SRC_ROWS, 16'(phases[p].sr));
      write_reg(REG_DST_COLS, 16'(phases[p].dc));
      write_reg(REG_DST_ROWS, 16'(phases[p].dr));
      write_reg(REG_COS_Q, phases[p].cq);
      write_reg(REG_SIN_Q, phases[p].sq);
      write_reg(REG_GRAY, 16'(phases[p].g));
      write_reg(REG_UNUSED, 16'($urandom));
      calm = phases[p].calm;
      fenced = phases[p].fenced;
      repeat (14) send(random_item());
      calm = 1'b0;
      fenced = 1'b0;
      settle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
